[design/mf3x3_pkg.sv]
package mf3x3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int SLOTS      = 3;
  localparam int SLOT_W     = 2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int DEF_DIM    = 128;
  localparam int WLAST_RST  = (DEF_DIM > MAX_WIDTH ? MAX_WIDTH : DEF_DIM) - 1;
  localparam int HLAST_RST  = (DEF_DIM > MAX_HEIGHT ? MAX_HEIGHT : DEF_DIM) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic SEL_UP    = 1'b0;
  localparam logic SEL_LO    = 1'b1;
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // raw column: rows r-2, r-1, r
  typedef struct packed {
    pix_t p2;
    pix_t p1;
    pix_t p0;
  } tri_t;

  // one window column, top to bottom (or min/med/max once sorted)
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    col_t l;
    col_t m;
    col_t r;
  } win_t;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } pos_flags_t;

  typedef struct packed {
    pix_t median;
    logic last;
    logic fend;
  } res_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input col_t c);
    col_t s;
    s.top = min3(c.top, c.mid, c.bot);
    s.mid = med3(c.top, c.mid, c.bot);
    s.bot = max3(c.top, c.mid, c.bot);
    return s;
  endfunction

endpackage

[design/median_filter_3x3.sv]
// Channel  Dir  Handshake            Word
// cfg      in   cfg_wr_en            cfg_index, cfg_data
// in       in   in_valid / in_stall  in_pixel
// out      out  out_valid / out_stall out_median, out_last_in_run, out_frame_end
//
// A pixel that releases n results (0..4) holds the median job issuer until all n are issued
// (it waits while queue credits are out); one result per cycle leaves the 3-stage median pipe.
// Line store: one 1024 x 24-bit RAM, one column of three rows per word,
// read on accept and written back as the pixel leaves S1 (forwarded when hit again).
// Reset (rst_n low, sync) clears counters and control; the RAM is not cleared.
// Results park in an 8-word queue; in_stall rises once queue credits run out.
module median_filter_3x3 import mf3x3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_median,
  output logic                 out_last_in_run,
  output logic                 out_frame_end
);

  // config and position
  logic [COL_W-1:0]  wlast_r;
  logic [ROW_W-1:0]  hlast_r;
  logic [COL_W-1:0]  in_col_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [SLOT_W-1:0] in_slot_r;
  logic [COL_W-1:0]  wlast_nxt;
  logic [ROW_W-1:0]  hlast_nxt;
  logic [IMG_W_W-1:0] cfg_w;
  logic [IMG_H_W-1:0] cfg_h;
  logic              in_acc;

  // line store
  logic [3*PIX_W-1:0] lstore [0:MAX_WIDTH-1];
  logic [3*PIX_W-1:0] rd_data_r;
  logic [COL_W-1:0]   rd_addr;
  logic               wb_valid_r;
  logic [COL_W-1:0]   wb_addr_r;
  logic [3*PIX_W-1:0] wb_data_r;
  logic [3*PIX_W-1:0] rword;
  logic [3*PIX_W-1:0] wword;

  // S1: data back from RAM
  logic              s1_valid_r;
  pix_t              s1_pix_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [SLOT_W-1:0] s1_slot_r;
  pos_flags_t        s1_flags_r;
  pos_flags_t        acc_flags;
  logic              s1_adv;
  logic              s1_jobs;
  logic [SLOT_W-1:0] slot_m1;
  logic [SLOT_W-1:0] slot_m2;
  tri_t              cur_col;
  tri_t              prev1_r;
  tri_t              prev2_r;

  // job group
  logic              g_valid_r;
  logic              g_ysel_r;
  logic              g_xsel_r;
  pos_flags_t        g_flags_r;
  tri_t              g_cur_r;
  tri_t              g_prev1_r;
  tri_t              g_prev2_r;
  logic              g_last;
  logic              g_issue;
  logic              g_finish;
  tri_t              sel_l;
  tri_t              sel_m;
  tri_t              sel_r;
  win_t              job_win;

  // median pipe
  logic              j_valid_r;
  win_t              j_win_r;
  logic              j_last_r;
  logic              j_fend_r;
  logic              a_valid_r;
  win_t              a_win_r;
  logic              a_last_r;
  logic              a_fend_r;
  logic              b_valid_r;
  col_t              b_val_r;
  logic              b_last_r;
  logic              b_fend_r;

  // result queue
  res_t               fifo_mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [CNT_W-1:0]   fifo_cnt_r;
  logic [CNT_W-1:0]   res_r;
  logic               pop;
  res_t               head;

  function automatic col_t pick_rows(input tri_t t, input logic ysel, input pos_flags_t f);
    col_t c;
    if (ysel == SEL_UP) begin
      c.top = f.r_ge2 ? t.p2 : t.p1;
      c.mid = t.p1;
      c.bot = t.p0;
    end else begin
      c.top = f.r_ge1 ? t.p1 : t.p0;
      c.mid = t.p0;
      c.bot = t.p0;
    end
    return c;
  endfunction

  // ---------------- config ----------------
  assign cfg_w = cfg_data[IMG_W_W-1:0];
  assign cfg_h = cfg_data[IMG_H_W-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      wlast_nxt = '0;
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      wlast_nxt = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast_nxt = COL_W'(cfg_w - IMG_W_W'(1));
    end
    if (cfg_h == '0) begin
      hlast_nxt = '0;
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      hlast_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast_nxt = ROW_W'(cfg_h - IMG_H_W'(1));
    end
  end

  // ---------------- accept ----------------
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    acc_flags.r_ge1  = (in_row_r != '0);
    acc_flags.r_ge2  = (in_row_r >= ROW_W'(2));
    acc_flags.r_last = (in_row_r == hlast_r);
    acc_flags.c_ge1  = (in_col_r != '0);
    acc_flags.c_ge2  = (in_col_r >= COL_W'(2));
    acc_flags.c_last = (in_col_r == wlast_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r   <= COL_W'(WLAST_RST);
      hlast_r   <= ROW_W'(HLAST_RST);
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_slot_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        wlast_r <= wlast_nxt;
      end else begin
        hlast_r <= hlast_nxt;
      end
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_slot_r <= '0;
    end else if (in_acc) begin
      if (acc_flags.c_last) begin
        in_col_r <= '0;
        if (acc_flags.r_last) begin
          in_row_r  <= '0;
          in_slot_r <= '0;
        end else begin
          in_row_r  <= in_row_r + ROW_W'(1);
          in_slot_r <= (in_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : in_slot_r + SLOT_W'(1);
        end
      end else begin
        in_col_r <= in_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_pixel;
      s1_col_r   <= in_col_r;
      s1_slot_r  <= in_slot_r;
      s1_flags_r <= acc_flags;
    end
  end

  // ---------------- line store RMW ----------------
  assign rd_addr = (s1_valid_r && !s1_adv) ? s1_col_r : in_col_r;

  always_ff @(posedge clk) begin
    rd_data_r <= lstore[rd_addr];
    if (s1_adv) begin
      lstore[s1_col_r] <= wword;
    end
  end

  always_comb begin
    rword = (wb_valid_r && wb_addr_r == s1_col_r) ? wb_data_r : rd_data_r;
    slot_m1 = (s1_slot_r == '0) ? SLOT_W'(2) : s1_slot_r - SLOT_W'(1);
    slot_m2 = (s1_slot_r == SLOT_W'(2)) ? '0 : s1_slot_r + SLOT_W'(1);
    wword = rword;
    for (int k = 0; k < SLOTS; k++) begin
      if (s1_slot_r == SLOT_W'(k)) begin
        wword[k*PIX_W +: PIX_W] = s1_pix_r;
      end
    end
    cur_col.p2 = rword[slot_m2*PIX_W +: PIX_W];
    cur_col.p1 = rword[slot_m1*PIX_W +: PIX_W];
    cur_col.p0 = s1_pix_r;
  end

  assign s1_jobs = (s1_flags_r.r_ge1 || s1_flags_r.r_last) &&
                   (s1_flags_r.c_ge1 || s1_flags_r.c_last);
  assign s1_adv  = s1_valid_r && (!g_valid_r || g_finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      wb_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wb_addr_r <= s1_col_r;
      wb_data_r <= wword;
      prev2_r   <= prev1_r;
      prev1_r   <= cur_col;
      g_flags_r <= s1_flags_r;
      g_cur_r   <= cur_col;
      g_prev1_r <= prev1_r;
      g_prev2_r <= prev2_r;
    end
  end

  // ---------------- job issue ----------------
  assign g_last = ((g_xsel_r == SEL_RIGHT) || !g_flags_r.c_last) &&
                  ((g_ysel_r == SEL_LO) || !g_flags_r.r_last);
  assign g_issue  = g_valid_r && (res_r < CNT_W'(FIFO_DEPTH));
  assign g_finish = g_issue && g_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
      g_ysel_r  <= SEL_UP;
      g_xsel_r  <= SEL_LEFT;
    end else if (s1_adv && s1_jobs) begin
      g_valid_r <= 1'b1;
      g_ysel_r  <= s1_flags_r.r_ge1 ? SEL_UP : SEL_LO;
      g_xsel_r  <= s1_flags_r.c_ge1 ? SEL_LEFT : SEL_RIGHT;
    end else if (g_finish) begin
      g_valid_r <= 1'b0;
    end else if (g_issue) begin
      if (g_xsel_r == SEL_LEFT && g_flags_r.c_last) begin
        g_xsel_r <= SEL_RIGHT;
      end else begin
        g_ysel_r <= SEL_LO;
        g_xsel_r <= g_flags_r.c_ge1 ? SEL_LEFT : SEL_RIGHT;
      end
    end
  end

  always_comb begin
    if (g_xsel_r == SEL_LEFT) begin
      sel_l = g_flags_r.c_ge2 ? g_prev2_r : g_prev1_r;
      sel_m = g_prev1_r;
      sel_r = g_cur_r;
    end else begin
      sel_l = g_flags_r.c_ge1 ? g_prev1_r : g_cur_r;
      sel_m = g_cur_r;
      sel_r = g_cur_r;
    end
    job_win.l = pick_rows(sel_l, g_ysel_r, g_flags_r);
    job_win.m = pick_rows(sel_m, g_ysel_r, g_flags_r);
    job_win.r = pick_rows(sel_r, g_ysel_r, g_flags_r);
  end

  // ---------------- median pipe ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      j_valid_r <= g_issue;
      a_valid_r <= j_valid_r;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    j_win_r   <= job_win;
    j_last_r  <= g_last;
    j_fend_r  <= (g_ysel_r == SEL_LO) && (g_xsel_r == SEL_RIGHT);
    a_win_r.l <= sort3(j_win_r.l);
    a_win_r.m <= sort3(j_win_r.m);
    a_win_r.r <= sort3(j_win_r.r);
    a_last_r  <= j_last_r;
    a_fend_r  <= j_fend_r;
    b_val_r.top <= max3(a_win_r.l.top, a_win_r.m.top, a_win_r.r.top);
    b_val_r.mid <= med3(a_win_r.l.mid, a_win_r.m.mid, a_win_r.r.mid);
    b_val_r.bot <= min3(a_win_r.l.bot, a_win_r.m.bot, a_win_r.r.bot);
    b_last_r  <= a_last_r;
    b_fend_r  <= a_fend_r;
  end

  // ---------------- result queue ----------------
  assign head            = fifo_mem[rd_ptr_r];
  assign out_valid       = (fifo_cnt_r != '0);
  assign out_median      = head.median;
  assign out_last_in_run = head.last;
  assign out_frame_end   = head.fend;
  assign pop             = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      fifo_mem[wr_ptr_r] <= '{median: med3(b_val_r.top, b_val_r.mid, b_val_r.bot),
                              last: b_last_r, fend: b_fend_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      res_r      <= '0;
    end else begin
      if (b_valid_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(b_valid_r) - CNT_W'(pop);
      res_r      <= res_r + CNT_W'(g_issue) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= res_r)
    else $error("queue holds more words than were issued");

  a_group_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && g_valid_r && !g_finish))
    else $error("job group overwritten before its last job");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_last_in_run)
    else $error("frame end word not last of its run");

  a_wb_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (wb_valid_r && wb_addr_r == $past(s1_col_r)))
    else $error("write-back forward entry lost");
`endif

endmodule

[test/median_filter_3x3_checker.sv]
`timescale 1ns / 1ps

module median_filter_3x3_checker import mf3x3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     out_median,
  input  logic                 out_last_in_run,
  input  logic                 out_frame_end,
  output int                   mismatches,
  output int                   outstanding
);

  logic [PIX_W-1:0]   rows [0:3*MAX_WIDTH-1];
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  int                 cur_row;
  int                 cur_col;
  res_t               medians_due [$];
  int                 errs;

  function automatic int width_used();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int height_used();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  // edge pixels repeat outward
  function automatic logic [PIX_W-1:0] window_median(int y, int x, int w, int h);
    logic [PIX_W-1:0] win [9];
    logic [PIX_W-1:0] v;
    int n;
    int ry;
    int rx;
    int k;
    n = 0;
    for (int j = -1; j <= 1; j++) begin
      for (int i = -1; i <= 1; i++) begin
        ry = y + j;
        rx = x + i;
        if (ry < 0) ry = 0;
        if (ry > h - 1) ry = h - 1;
        if (rx < 0) rx = 0;
        if (rx > w - 1) rx = w - 1;
        win[n] = rows[(ry % 3) * MAX_WIDTH + rx];
        n++;
      end
    end
    for (int i = 1; i < 9; i++) begin
      v = win[i];
      k = i - 1;
      while (k >= 0 && win[k] > v) begin
        win[k+1] = win[k];
        k--;
      end
      win[k+1] = v;
    end
    return win[4];
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] pix);
    int   w;
    int   h;
    int   r;
    int   c;
    int   ny;
    int   nx;
    int   total;
    int   k;
    int   ys [2];
    int   xs [2];
    res_t res;
    w  = width_used();
    h  = height_used();
    r  = cur_row;
    c  = cur_col;
    ny = 0;
    nx = 0;
    if (r >= h) r = h - 1;
    if (c >= w) c = w - 1;
    rows[(r % 3) * MAX_WIDTH + c] = pix;
    if (r >= 1) begin
      ys[ny] = r - 1;
      ny++;
    end
    if (r == h - 1) begin
      ys[ny] = r;
      ny++;
    end
    if (c >= 1) begin
      xs[nx] = c - 1;
      nx++;
    end
    if (c == w - 1) begin
      xs[nx] = c;
      nx++;
    end
    total = ny * nx;
    k = 0;
    for (int a = 0; a < ny; a++) begin
      for (int b = 0; b < nx; b++) begin
        res.median = window_median(ys[a], xs[b], w, h);
        res.last   = (k == total - 1);
        res.fend   = (ys[a] == h - 1) && (xs[b] == w - 1);
        medians_due.push_back(res);
        k++;
      end
    end
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3 * MAX_WIDTH; i++) rows[i] = '0;
      width_reg  = IMG_W_W'(DEF_DIM);
      height_reg = IMG_H_W'(DEF_DIM);
      cur_row    = 0;
      cur_col    = 0;
      medians_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[IMG_W_W-1:0];
        if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data[IMG_H_W-1:0];
        cur_row = 0;
        cur_col = 0;
      end
      if (in_valid && !in_stall) take_pixel(in_pixel);
      if (out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          $error("unexpected word: median %0d last_in_run %0d frame_end %0d",
                 out_median, out_last_in_run, out_frame_end);
          errs++;
        end else begin
          want = medians_due.pop_front();
          if (out_median !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, out_median);
            errs++;
          end
          if (out_last_in_run !== want.last) begin
            $error("last_in_run: expected %0d, got %0d", want.last, out_last_in_run);
            errs++;
          end
          if (out_frame_end !== want.fend) begin
            $error("frame_end: expected %0d, got %0d", want.fend, out_frame_end);
            errs++;
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= medians_due.size();
  end

endmodule

[test/median_filter_3x3_tb.sv]
`timescale 1ns / 1ps

module median_filter_3x3_tb import mf3x3_pkg::*;;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data        = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel        = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [PIX_W-1:0]     out_median;
  logic                 out_last_in_run;
  logic                 out_frame_end;
  int                   mismatches;
  int                   outstanding;

  logic                 calm            = 1'b0;
  logic                 hold_req        = 1'b0;
  logic                 hold_done       = 1'b0;
  int                   hold_left       = 0;

  logic [PIX_W-1:0]     checker_frame [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                              8'd128, 8'd1, 8'd254};

  median_filter_3x3 dut (.*);

  median_filter_3x3_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_IMAGE_WIDTH, wdata);
      write_reg(REG_IMAGE_HEIGHT, hdata);
    end else begin
      write_reg(REG_IMAGE_HEIGHT, hdata);
      write_reg(REG_IMAGE_WIDTH, wdata);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // drain every pending word, then let the pipe and line store write-back empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int               rand_items;
    int               phase;
    int               n;
    int               we;
    int               he;
    int               frame;
    logic [10:0]      wv;
    logic [12:0]      hv;
    logic [PIX_W-1:0] p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 4; i++) send_pixel(PIX_W'(i * 85));
    settle();
    set_dims(CFG_W'(3), CFG_W'(3));
    for (int i = 0; i < 9; i++) send_pixel(checker_frame[i]);
    settle();
    set_dims(CFG_W'(1), CFG_W'(3));
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    settle();
    set_dims(CFG_W'(0), CFG_W'(0));
    send_pixel(8'd255);
    send_pixel(8'd0);
    settle();
    set_dims(13'h1FFF, 13'h1FFF);
    for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom()));
    settle();

    rand_items = 0;
    phase = 0;
    while (rand_items < 240) begin
      if (phase == 0) begin
        wv = 11'd6;
        hv = 13'd5;
      end else if (phase == 1) begin
        wv = 11'd8;
        hv = 13'd6;
      end else begin
        case ($urandom_range(0, 9))
          0:       wv = '0;
          1:       wv = 11'($urandom_range(9, 64));
          2:       wv = 11'($urandom_range(1000, 2047));
          default: wv = 11'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
          0:       hv = '0;
          1:       hv = 13'($urandom_range(7, 30));
          2:       hv = 13'($urandom_range(4000, 8191));
          default: hv = 13'($urandom_range(1, 6));
        endcase
      end
      we = (wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : int'(wv));
      he = (hv == 0) ? 1 : ((hv > MAX_HEIGHT) ? MAX_HEIGHT : int'(hv));
      frame = we * he;
      set_dims({2'($urandom_range(0, 3)), wv}, hv);
      calm     <= (phase == 1);
      hold_req <= (phase == 0);
      if (phase == 0 || phase == 1) n = 2 * frame;
      else if (frame <= 64 && $urandom_range(0, 4) != 0) n = frame * $urandom_range(1, 2);
      else n = $urandom_range(1, 40);
      if (n > 240 - rand_items) n = 240 - rand_items;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0:       p = '0;
          1:       p = '1;
          default: p = PIX_W'($urandom());
        endcase
        send_pixel(p);
      end
      rand_items += n;
      phase++;
      settle();
    end

    if (mismatches == 0) begin
      $display("[median_filter_3x3] OK");
    end else begin
      $display("[median_filter_3x3] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[median_filter_3x3] ERROR");
    $finish;
  end

endmodule
